@@ design/fscs_pkg.sv @@
`default_nettype none

package fscs_pkg;

  // register file layout
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_STEP       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CREDIT       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CREDIT_PER_QUERY = 2'd2;

  localparam int FIXED_STEP_W       = 32;
  localparam int MAX_CREDIT_W       = 16;
  localparam int CREDIT_PER_QUERY_W = 16;

  localparam logic [FIXED_STEP_W-1:0]       FIXED_STEP_RESET       = 32'd16667;
  localparam logic [MAX_CREDIT_W-1:0]       MAX_CREDIT_RESET       = 16'd200;
  localparam logic [CREDIT_PER_QUERY_W-1:0] CREDIT_PER_QUERY_RESET = 16'd4;

  // result field widths
  localparam int COUNT_W    = 16;
  localparam int STEP_OUT_W = 48;

  localparam logic CMD_QUERY   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } fscs_div_status_t;

endpackage

`default_nettype wire

@@ design/fscs_div.sv @@
`default_nettype none

module fscs_div
  import fscs_pkg::*;
#(
  parameter int WIDTH = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic      [WIDTH-1:0] quot,
  output fscs_div_status_t      status
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;

  // one quotient bit per cycle, dividend bits shift out msb first
  assign shifted = {r, q[WIDTH-1]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      if (!trial[WIDTH]) begin
        r <= trial[WIDTH-1:0];
        q <= {q[WIDTH-2:0], 1'b1};
      end else begin
        r <= shifted[WIDTH-1:0];
        q <= {q[WIDTH-2:0], 1'b0};
      end
    end
  end

  // rounds up; no overflow for a nonzero divisor, since a divisor of one leaves no remainder
  assign quot   = q + WIDTH'(r != '0);
  assign status = {busy, done};

endmodule

`default_nettype wire

@@ design/fixed_step_credit_scheduler.sv @@
// sequence: an advance goes straight to the result; a query that is not due skips
// the divider; a due query with enough credit uses one divide, and one with a
// stretched step uses three, run one after another in the divider
// throughput: one item at a time; the next is taken once the result sits in
// the output register, so a waiting result does not block the next beat
// reset: config registers to defaults, pool full, first query pending
`default_nettype none

module fixed_step_credit_scheduler
  import fscs_pkg::*;
#(
  parameter int TIME_WIDTH   = 48,
  parameter int CREDIT_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    cmd,
  input  wire logic [TIME_WIDTH-1:0]   current_time_us,
  input  wire logic [TIME_WIDTH-1:0]   advance_amount,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [COUNT_W-1:0]      granted_count,
  output logic      [STEP_OUT_W-1:0]   granted_step_us
);

  localparam int REFILL_W = ((CREDIT_WIDTH > MAX_CREDIT_W) ? CREDIT_WIDTH : MAX_CREDIT_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV1   = 3'd2;
  localparam logic [2:0] S_DIV2   = 3'd3;
  localparam logic [2:0] S_DIV3   = 3'd4;
  localparam logic [2:0] S_REFILL = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [FIXED_STEP_W-1:0]       fixed_step_us;
  logic [MAX_CREDIT_W-1:0]       max_credit;
  logic [CREDIT_PER_QUERY_W-1:0] credit_per_query;

  logic [2:0]              state;
  logic [TIME_WIDTH-1:0]   last_time;
  logic                    awaiting;
  logic [CREDIT_WIDTH-1:0] pool;
  logic [TIME_WIDTH-1:0]   now;
  logic [TIME_WIDTH-1:0]   step;
  logic [TIME_WIDTH-1:0]   amount;
  logic [CREDIT_WIDTH-1:0] count;

  logic                    in_accept;
  logic                    out_free;
  logic [TIME_WIDTH-1:0]   step_eff;
  logic [TIME_WIDTH-1:0]   due_time;
  logic                    due;
  logic [TIME_WIDTH-1:0]   elapsed;
  logic [TIME_WIDTH-1:0]   amount_next;
  logic [TIME_WIDTH-1:0]   pool_wide;
  logic                    over_pool;
  logic                    div_start;
  logic [TIME_WIDTH-1:0]   div_dividend;
  logic [TIME_WIDTH-1:0]   div_divisor;
  logic [TIME_WIDTH-1:0]   quot;
  fscs_div_status_t        div_status;
  logic [REFILL_W-1:0]     refill;
  logic [REFILL_W-1:0]     refill_sat;
  logic [CREDIT_WIDTH+COUNT_W-1:0]  count_wide;
  logic [TIME_WIDTH+STEP_OUT_W-1:0] step_wide;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // a zero step register counts as one
  assign step_eff = (fixed_step_us == '0) ? TIME_WIDTH'(1) : TIME_WIDTH'(fixed_step_us);

  assign due_time    = last_time + step;
  assign due         = (due_time <= now);
  assign elapsed     = now - last_time;
  assign amount_next = (elapsed > step) ? elapsed : step;

  assign pool_wide = TIME_WIDTH'(pool);
  assign over_pool = (quot > pool_wide);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = amount;
    div_divisor  = step;
    unique case (state)
      S_CHECK: begin
        div_start    = due;
        div_dividend = amount_next;
      end
      S_DIV1: begin
        div_start   = div_status.done && over_pool && (pool != '0);
        div_divisor = pool_wide;
      end
      S_DIV2: begin
        div_start   = div_status.done;
        div_divisor = quot;
      end
      default: begin
      end
    endcase
  end

  fscs_div #(
    .WIDTH(TIME_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quot    (quot),
    .status  (div_status)
  );

  assign refill     = REFILL_W'(pool - count) + REFILL_W'(credit_per_query);
  assign refill_sat = (refill > REFILL_W'(max_credit)) ? REFILL_W'(max_credit) : refill;

  assign count_wide = (CREDIT_WIDTH + COUNT_W)'(count);
  assign step_wide  = (TIME_WIDTH + STEP_OUT_W)'(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_step_us    <= FIXED_STEP_RESET;
      max_credit       <= MAX_CREDIT_RESET;
      credit_per_query <= CREDIT_PER_QUERY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FIXED_STEP:       fixed_step_us    <= cfg_data[FIXED_STEP_W-1:0];
        REG_MAX_CREDIT:       max_credit       <= cfg_data[MAX_CREDIT_W-1:0];
        REG_CREDIT_PER_QUERY: credit_per_query <= cfg_data[CREDIT_PER_QUERY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_time <= '0;
      awaiting  <= 1'b1;
      pool      <= CREDIT_WIDTH'(MAX_CREDIT_RESET);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (cmd == CMD_ADVANCE) begin
              last_time <= last_time + advance_amount;
              state     <= S_EMIT;
            end else begin
              if (awaiting) begin
                last_time <= current_time_us;
                awaiting  <= 1'b0;
              end
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: state <= due ? S_DIV1 : S_EMIT;
        S_DIV1: begin
          if (div_status.done) begin
            state <= (over_pool && (pool != '0)) ? S_DIV2 : S_REFILL;
          end
        end
        S_DIV2: begin
          if (div_status.done) begin
            state <= S_DIV3;
          end
        end
        S_DIV3: begin
          if (div_status.done) begin
            state <= S_REFILL;
          end
        end
        S_REFILL: begin
          pool  <= refill_sat[CREDIT_WIDTH-1:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        now   <= current_time_us;
        step  <= (cmd == CMD_ADVANCE) ? '0 : step_eff;
        count <= '0;
      end
      S_CHECK: begin
        amount <= amount_next;
        if (!due) begin
          step <= '0;
        end
      end
      S_DIV1: begin
        if (div_status.done) begin
          if (!over_pool) begin
            count <= quot[CREDIT_WIDTH-1:0];
          end else if (pool == '0) begin
            step <= '0;
          end
        end
      end
      S_DIV2: begin
        if (div_status.done) begin
          step <= quot;
        end
      end
      S_DIV3: begin
        if (div_status.done) begin
          count <= quot[CREDIT_WIDTH-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      granted_count   <= count_wide[COUNT_W-1:0];
      granted_step_us <= step_wide[STEP_OUT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == S_DIV1 || state == S_DIV2 || state == S_DIV3))
    else $error("divider finished outside a divide state");

  a_count_within_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFILL) |-> (count <= pool))
    else $error("granted count exceeds credit pool");

  a_zero_together: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((granted_count == '0) == (granted_step_us == '0)))
    else $error("count and step disagree on an empty grant");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("second beat taken while one is in work");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire
